FILE: hdl/rvd_pkg.sv
// Shared types and constants of the radial vertex dent block.
`default_nettype none
package rvd_pkg;

	localparam int SQRT_CELLS = 31;
	localparam int DIV_CELLS  = 27;

	localparam logic [26:0] RADIUS_BASE = 27'(55 * 65536);
	localparam logic [26:0] STEP_BASE   = 27'(10 * 65536);
	localparam logic [32:0] TARGET_Y    = 33'(30 * 65536);

	// Reciprocals scaled by 2^42; exact floor for dividends below 2^32.
	localparam int RECIP_SHIFT = 42;
	localparam logic [37:0] RAD_M_NORMAL  = 38'(((64'd1 << RECIP_SHIFT) + 64'd39) / 64'd40);
	localparam logic [37:0] RAD_M_FRONT   = 38'(((64'd1 << RECIP_SHIFT) + 64'd199) / 64'd200);
	localparam logic [37:0] STEP_M_NORMAL = 38'(((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60);
	localparam logic [37:0] STEP_M_FRONT  = 38'(((64'd1 << RECIP_SHIFT) + 64'd299) / 64'd300);
	localparam int RECIP_POST = RECIP_SHIFT - 16;

	typedef enum logic [2:0] {
		CFG_CENTRE_X,
		CFG_CENTRE_Y,
		CFG_CENTRE_Z,
		CFG_IMPACT_DAMAGE,
		CFG_FRONT_HIT
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] moved_x;
		logic signed [31:0] moved_y;
		logic signed [31:0] moved_z;
		logic               was_dented;
		logic               end_of_mesh;
	} result_t;

	typedef struct packed {
		logic [2:0][31:0] v;
		logic [2:0]       neg;
		logic             last;
		logic             in_radius;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [26:0]      step;
		logic [2:0][29:0] e;
	} sqrt_pl_t;

	typedef struct packed {
		logic [61:0] rad;
		logic [32:0] rem;
		logic [30:0] root;
	} sqrt_work_t;

	typedef struct packed {
		side_t       side;
		logic [30:0] n;
	} div_pl_t;

	typedef struct packed {
		logic [2:0][30:0] rem;
		logic [2:0][26:0] w;
	} div_work_t;

endpackage
`default_nettype wire

FILE: hdl/radial_vertex_dent_top.sv
// Top level of the radial vertex dent block: front stages, cell chains and output queue.
//
// Vertices enter on the vtx channel (vtx_valid, vtx_stall, vtx) and leave one for one,
// in order, on the res channel (res_valid, res_stall, res). A transfer happens on an edge
// where valid is high and stall is low. The impact is set through the cfg write port
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high. The user must
// write the port only while no vertex is in flight; the block itself does not enforce it.
// A vertex passes from its transfer in to its result on res through three front
// stages, a chain of 31 square root cells, one multiply stage, a chain of 27 divider
// cells and a two-entry output queue. One vertex enters every cycle unless stalled.
// When the receiver holds res_stall, the queue fills and then the whole chain freezes
// in place and vtx_stall rises; nothing is dropped. vtx_stall depends only on the queue
// fill, so the input side sees a registered stall.
// Reset clears the impact registers to zero, all stage valid bits and the queue.
`default_nettype none
module radial_vertex_dent_top
	import rvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        vtx_valid,
	output logic             vtx_stall,
	input  vertex_t          vtx,
	output logic             res_valid,
	input  wire logic        res_stall,
	output result_t          res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] centre_x_q, centre_y_q, centre_z_q;
	logic [15:0] damage_q;
	logic        front_q;
	logic        en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			centre_z_q <= '0;
			damage_q   <= '0;
			front_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTRE_X:      centre_x_q <= cfg_data;
				CFG_CENTRE_Y:      centre_y_q <= cfg_data;
				CFG_CENTRE_Z:      centre_z_q <= cfg_data;
				CFG_IMPACT_DAMAGE: damage_q   <= cfg_data[15:0];
				CFG_FRONT_HIT:     front_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: dent size, offsets from the epicentre and direction to the target.
	logic [53:0]      rad_prod, step_prod;
	logic [26:0]      rad_c, step_c;
	logic [2:0][31:0] v_c, c_c;
	logic [2:0][32:0] a_c, d_c, amag_c;
	logic [2:0][31:0] dmag_c;

	always_comb begin
		rad_prod  = 54'(damage_q) * 54'(front_q ? RAD_M_FRONT : RAD_M_NORMAL);
		step_prod = 54'(damage_q) * 54'(front_q ? STEP_M_FRONT : STEP_M_NORMAL);
		rad_c     = RADIUS_BASE + 27'(rad_prod >> RECIP_POST);
		step_c    = STEP_BASE + 27'(step_prod >> RECIP_POST);
		v_c[0] = vtx.vertex_x;
		v_c[1] = vtx.vertex_y;
		v_c[2] = vtx.vertex_z;
		c_c[0] = centre_x_q;
		c_c[1] = centre_y_q;
		c_c[2] = centre_z_q;
		for (int i = 0; i < 3; i++) begin
			a_c[i]    = {v_c[i][31], v_c[i]} - {c_c[i][31], c_c[i]};
			amag_c[i] = a_c[i][32] ? 33'(-a_c[i]) : a_c[i];
		end
		d_c[0] = 33'(0) - {v_c[0][31], v_c[0]};
		d_c[1] = TARGET_Y - {v_c[1][31], v_c[1]};
		d_c[2] = 33'(0) - {v_c[2][31], v_c[2]};
		for (int i = 0; i < 3; i++) begin
			dmag_c[i] = d_c[i][32] ? 32'(-d_c[i]) : 32'(d_c[i]);
		end
	end

	logic             valid_s1;
	side_t            side_s1;
	logic [26:0]      rad_s1, step_s1;
	logic [2:0][32:0] amag_s1;
	logic [2:0][31:0] dmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vtx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.v         <= v_c;
			side_s1.neg       <= {d_c[2][32], d_c[1][32], d_c[0][32]};
			side_s1.last      <= vtx.last_vertex;
			side_s1.in_radius <= 1'b0;
			rad_s1            <= rad_c;
			step_s1           <= step_c;
			amag_s1           <= amag_c;
			dmag_s1           <= dmag_c;
		end
	end

	// Stage 2: squares for the in-radius test and the scaled direction.
	logic [2:0]       over_c;
	logic [2:0][53:0] sq_c;
	logic [53:0]      rsq_c;
	logic [31:0]      m_c;
	logic [2:0][29:0] e_c;

	always_comb begin
		rsq_c = 54'(rad_s1) * 54'(rad_s1);
		m_c   = dmag_s1[0];
		for (int i = 0; i < 3; i++) begin
			over_c[i] = amag_s1[i] > 33'(rad_s1);
			sq_c[i]   = 54'(amag_s1[i][26:0]) * 54'(amag_s1[i][26:0]);
			if (dmag_s1[i] > m_c) begin
				m_c = dmag_s1[i];
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (m_c[31]) begin
				e_c[i] = 30'(dmag_s1[i] >> 2);
			end else if (m_c[30]) begin
				e_c[i] = 30'(dmag_s1[i] >> 1);
			end else begin
				e_c[i] = dmag_s1[i][29:0];
			end
		end
	end

	logic             valid_s2;
	side_t            side_s2;
	logic [26:0]      step_s2;
	logic             over_s2;
	logic [2:0][53:0] sq_s2;
	logic [53:0]      rsq_s2;
	logic [2:0][29:0] e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			step_s2 <= step_s1;
			over_s2 <= |over_c;
			sq_s2   <= sq_c;
			rsq_s2  <= rsq_c;
			e_s2    <= e_c;
		end
	end

	// Stage 3: distance compare and squared direction components.
	logic [55:0]      dist_c;
	logic [2:0][59:0] esq_c;

	always_comb begin
		dist_c = 56'(sq_s2[0]) + 56'(sq_s2[1]) + 56'(sq_s2[2]);
		for (int i = 0; i < 3; i++) begin
			esq_c[i] = 60'(e_s2[i]) * 60'(e_s2[i]);
		end
	end

	logic             valid_s3;
	side_t            side_s3;
	logic [26:0]      step_s3;
	logic [2:0][29:0] e_s3;
	logic [2:0][59:0] esq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.v         <= side_s2.v;
			side_s3.neg       <= side_s2.neg;
			side_s3.last      <= side_s2.last;
			side_s3.in_radius <= !over_s2 && (dist_c <= 56'(rsq_s2));
			step_s3           <= step_s2;
			e_s3              <= e_s2;
			esq_s3            <= esq_c;
		end
	end

	// Square root chain: the length of the scaled direction.
	logic       sq_valid [0:SQRT_CELLS];
	sqrt_work_t sq_work  [0:SQRT_CELLS];
	sqrt_pl_t   sq_pl    [0:SQRT_CELLS];

	always_comb begin
		sq_valid[0]      = valid_s3;
		sq_work[0].rad   = 62'(esq_s3[0]) + 62'(esq_s3[1]) + 62'(esq_s3[2]);
		sq_work[0].rem   = '0;
		sq_work[0].root  = '0;
		sq_pl[0].side    = side_s3;
		sq_pl[0].step    = step_s3;
		sq_pl[0].e       = e_s3;
	end

	for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
		rvd_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (sq_valid[g]),
			.up_work  (sq_work[g]),
			.up_pl    (sq_pl[g]),
			.dn_valid (sq_valid[g+1]),
			.dn_work  (sq_work[g+1]),
			.dn_pl    (sq_pl[g+1])
		);
	end

	// Stage 5: numerators of the three move components.
	logic             valid_s5;
	side_t            side_s5;
	logic [30:0]      n_s5;
	logic [2:0][56:0] num_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= sq_valid[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= sq_pl[SQRT_CELLS].side;
			n_s5    <= sq_work[SQRT_CELLS].root;
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= 57'(sq_pl[SQRT_CELLS].step) * 57'(sq_pl[SQRT_CELLS].e[i]);
			end
		end
	end

	// Divider chain: step * e / n, one quotient bit per cell.
	logic      dv_valid [0:DIV_CELLS];
	div_work_t dv_work  [0:DIV_CELLS];
	div_pl_t   dv_pl    [0:DIV_CELLS];

	always_comb begin
		dv_valid[0]   = valid_s5;
		dv_pl[0].side = side_s5;
		dv_pl[0].n    = n_s5;
		for (int i = 0; i < 3; i++) begin
			dv_work[0].rem[i] = 31'(num_s5[i][56:27]);
			dv_work[0].w[i]   = num_s5[i][26:0];
		end
	end

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
		rvd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (dv_valid[g]),
			.up_work  (dv_work[g]),
			.up_pl    (dv_pl[g]),
			.dn_valid (dv_valid[g+1]),
			.dn_work  (dv_work[g+1]),
			.dn_pl    (dv_pl[g+1])
		);
	end

	// Apply the move with saturation.
	side_t            fin_side;
	logic             dent_c;
	logic [2:0][32:0] sum_c;
	logic [2:0][31:0] out_c;
	result_t          res_c;

	always_comb begin
		fin_side = dv_pl[DIV_CELLS].side;
		dent_c   = fin_side.in_radius && (dv_pl[DIV_CELLS].n != '0);
		for (int i = 0; i < 3; i++) begin
			if (fin_side.neg[i]) begin
				sum_c[i] = {fin_side.v[i][31], fin_side.v[i]} - 33'(dv_work[DIV_CELLS].w[i]);
			end else begin
				sum_c[i] = {fin_side.v[i][31], fin_side.v[i]} + 33'(dv_work[DIV_CELLS].w[i]);
			end
			if (!dent_c) begin
				out_c[i] = fin_side.v[i];
			end else if (sum_c[i][32] != sum_c[i][31]) begin
				out_c[i] = sum_c[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				out_c[i] = sum_c[i][31:0];
			end
		end
		res_c.moved_x     = out_c[0];
		res_c.moved_y     = out_c[1];
		res_c.moved_z     = out_c[2];
		res_c.was_dented  = dent_c;
		res_c.end_of_mesh = fin_side.last;
	end

	// Output queue of two entries; the chain runs while it has room.
	result_t     fifo_q [0:1];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign en        = cnt_q != 2'd2;
	assign vtx_stall = !en;
	assign push      = en && dv_valid[DIV_CELLS];
	assign res_valid = cnt_q != 2'd0;
	assign pop       = res_valid && !res_stall;
	assign res       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_c;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/rvd_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain.
`default_nettype none
module rvd_sqrt_cell
	import rvd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       up_valid,
	input  sqrt_work_t      up_work,
	input  sqrt_pl_t        up_pl,
	output logic            dn_valid,
	output sqrt_work_t      dn_work,
	output sqrt_pl_t        dn_pl
);

	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic        ge;
	sqrt_work_t  work_nx;
	logic        valid_q;
	sqrt_work_t  work_q;
	sqrt_pl_t    pl_q;

	always_comb begin
		rem_sh = {up_work.rem, up_work.rad[61:60]};
		trial  = {2'b00, up_work.root, 2'b01};
		ge     = rem_sh >= trial;
		work_nx.rad  = {up_work.rad[59:0], 2'b00};
		work_nx.rem  = ge ? 33'(rem_sh - trial) : 33'(rem_sh);
		work_nx.root = {up_work.root[29:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= work_nx;
			pl_q   <= up_pl;
		end
	end

	assign dn_valid = valid_q;
	assign dn_work  = work_q;
	assign dn_pl    = pl_q;

endmodule
`default_nettype wire

FILE: hdl/rvd_div_cell.sv
// One quotient-bit cell of the three-lane restoring divider chain.
`default_nettype none
module rvd_div_cell
	import rvd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       up_valid,
	input  div_work_t       up_work,
	input  div_pl_t         up_pl,
	output logic            dn_valid,
	output div_work_t       dn_work,
	output div_pl_t         dn_pl
);

	logic [2:0][31:0] rem_sh;
	logic [2:0]       ge;
	div_work_t        work_nx;
	logic             valid_q;
	div_work_t        work_q;
	div_pl_t          pl_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {up_work.rem[i], up_work.w[i][26]};
			ge[i]     = rem_sh[i] >= {1'b0, up_pl.n};
			work_nx.rem[i] = ge[i] ? 31'(rem_sh[i] - {1'b0, up_pl.n}) : 31'(rem_sh[i]);
			work_nx.w[i]   = {up_work.w[i][25:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= work_nx;
			pl_q   <= up_pl;
		end
	end

	assign dn_valid = valid_q;
	assign dn_work  = work_q;
	assign dn_pl    = pl_q;

endmodule
`default_nettype wire

FILE: dv/rvd_checker.sv
// Predictor and scoreboard for the radial vertex dent block.
`default_nettype none
module rvd_checker
	import rvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        vtx_valid,
	input  wire logic        vtx_stall,
	input  vertex_t          vtx,
	input  wire logic        res_valid,
	input  wire logic        res_stall,
	input  result_t          res,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               dented_count
);

	logic signed [63:0] epi [3];
	logic [15:0] damage;
	logic        front;
	result_t     dent_queue [$];

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic result_t dent_vertex(input vertex_t vin);
		logic signed [63:0] v [3];
		logic signed [63:0] d [3];
		logic signed [63:0] s;
		logic [63:0] radius, step, dist_sq, a, m, n, mv;
		logic [63:0] e [3];
		logic in_radius, moved;
		int k;
		result_t r;
		v[0] = 64'(vin.vertex_x);
		v[1] = 64'(vin.vertex_y);
		v[2] = 64'(vin.vertex_z);
		radius = 64'd55 * 65536 + 64'(damage) * 65536 / (front ? 200 : 40);
		step   = 64'd10 * 65536 + 64'(damage) * 65536 / (front ? 300 : 60);
		in_radius = 1;
		dist_sq = 0;
		for (int i = 0; i < 3; i++) begin
			s = v[i] - epi[i];
			a = s < 0 ? -s : s;
			if (a > radius) in_radius = 0;
			else dist_sq += a * a;
		end
		if (in_radius && dist_sq > radius * radius) in_radius = 0;
		moved = 0;
		r.moved_x = vin.vertex_x;
		r.moved_y = vin.vertex_y;
		r.moved_z = vin.vertex_z;
		if (in_radius) begin
			d[0] = -v[0];
			d[1] = 64'sd30 * 65536 - v[1];
			d[2] = -v[2];
			m = 0;
			for (int i = 0; i < 3; i++) begin
				a = d[i] < 0 ? -d[i] : d[i];
				if (a > m) m = a;
			end
			k = 0;
			while ((m >> k) >= (64'd1 << 30)) k++;
			n = 0;
			for (int i = 0; i < 3; i++) begin
				e[i] = (d[i] < 0 ? -d[i] : d[i]) >> k;
				n += e[i] * e[i];
			end
			n = root64(n);
			if (n != 0) begin
				moved = 1;
				for (int i = 0; i < 3; i++) begin
					mv = step * e[i] / n;
					s = d[i] < 0 ? v[i] - $signed(mv) : v[i] + $signed(mv);
					if (s > 64'sd2147483647) s = 64'sd2147483647;
					if (s < -64'sd2147483648) s = -64'sd2147483648;
					if (i == 0) r.moved_x = s[31:0];
					else if (i == 1) r.moved_y = s[31:0];
					else r.moved_z = s[31:0];
				end
			end
		end
		r.was_dented = moved;
		r.end_of_mesh = vin.last_vertex;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int errs;
		if (!arst_n) begin
			epi[0] <= 0;
			epi[1] <= 0;
			epi[2] <= 0;
			damage <= 0;
			front <= 0;
			fail_count <= 0;
			pending <= 0;
			dented_count <= 0;
			dent_queue.delete();
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CENTRE_X: epi[0] <= 64'($signed(cfg_data));
					CFG_CENTRE_Y: epi[1] <= 64'($signed(cfg_data));
					CFG_CENTRE_Z: epi[2] <= 64'($signed(cfg_data));
					CFG_IMPACT_DAMAGE: damage <= cfg_data[15:0];
					CFG_FRONT_HIT: front <= cfg_data[0];
					default: ;
				endcase
			end
			if (vtx_valid && !vtx_stall) dent_queue.push_back(dent_vertex(vtx));
			if (res_valid && !res_stall) begin
				if (dent_queue.size() == 0) begin
					$error("result with no vertex outstanding");
					errs++;
				end else begin
					want = dent_queue.pop_front();
					if (want.was_dented) dented_count <= dented_count + 1;
					if (res.moved_x !== want.moved_x) begin
						$error("moved_x expected %0d actual %0d", want.moved_x, res.moved_x);
						errs++;
					end
					if (res.moved_y !== want.moved_y) begin
						$error("moved_y expected %0d actual %0d", want.moved_y, res.moved_y);
						errs++;
					end
					if (res.moved_z !== want.moved_z) begin
						$error("moved_z expected %0d actual %0d", want.moved_z, res.moved_z);
						errs++;
					end
					if (res.was_dented !== want.was_dented) begin
						$error("was_dented expected %0b actual %0b", want.was_dented,
							res.was_dented);
						errs++;
					end
					if (res.end_of_mesh !== want.end_of_mesh) begin
						$error("end_of_mesh expected %0b actual %0b", want.end_of_mesh,
							res.end_of_mesh);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= dent_queue.size();
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Stimulus and verdict for the radial vertex dent block.
`default_nettype none
module tb;
	import rvd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        vtx_valid = 0;
	logic        vtx_stall;
	vertex_t     vtx = '0;
	logic        res_valid;
	logic        res_stall = 1;
	result_t     res;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending, dented_count;
	int          cycles = 0;
	int          sent = 0;
	bit          hold_off = 0;

	always #1 clk = ~clk;

	radial_vertex_dent_top dut (.*);
	rvd_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("radial_vertex_dent_top test failed");
			$finish;
		end
	end

	// Receiver: random stall per result, with an occasional long hold-off.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				res_stall <= 1;
				repeat (150) @(posedge clk);
				hold_off = 0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if ($urandom_range(0, 2) == 0) w = 0;
			res_stall <= (w != 0);
			repeat (w) @(posedge clk);
			res_stall <= 0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	// Stop offering vertices and wait until every result has left the block.
	task automatic drain();
		vtx_valid <= 0;
		while (pending != 0 || (vtx_valid)) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_vertex(input vertex_t v, input bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 12) : 0;
		if (gaps && $urandom_range(0, 2) == 0) w = 0;
		if (w != 0) begin
			vtx_valid <= 0;
			repeat (w) @(posedge clk);
		end
		vtx_valid <= 1;
		vtx <= v;
		@(posedge clk);
		while (vtx_stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] near(input logic [31:0] base, input int spread);
		return base + 32'($signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	task automatic set_impact(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [15:0] dmg, input bit fr);
		cfg_write(CFG_CENTRE_X, cx);
		cfg_write(CFG_CENTRE_Y, cy);
		cfg_write(CFG_CENTRE_Z, cz);
		cfg_write(CFG_IMPACT_DAMAGE, {16'($urandom_range(0, 65535)), dmg});
		cfg_write(CFG_FRONT_HIT, {31'($urandom), fr});
	endtask

	function automatic vertex_t pick_vertex(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz);
		vertex_t v;
		int sel;
		int spread;
		sel = $urandom_range(0, 9);
		spread = (sel < 5) ? 60 * 65536 : 200 * 65536;
		if (sel < 8) begin
			v.vertex_x = near(cx, spread);
			v.vertex_y = near(cy, spread);
			v.vertex_z = near(cz, spread);
		end else begin
			v.vertex_x = $urandom;
			v.vertex_y = $urandom;
			v.vertex_z = $urandom;
		end
		v.last_vertex = ($urandom_range(0, 15) == 0);
		return v;
	endfunction

	initial begin
		logic [31:0] cx, cy, cz;
		logic [31:0] edges [6];
		vertex_t v;
		int phase;
		edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h001E_0000,
			32'h0000_0001};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extreme corners, the target point, the radius edge and wrap cases.
		set_impact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 0);
		for (int i = 0; i < 6; i++) begin
			send_vertex('{edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6], i[0]}, 0);
		end
		send_vertex('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1}, 0);
		drain();
		set_impact(32'h0, 32'h001E_0000, 32'h0, 16'd0, 0);
		send_vertex('{32'h0, 32'h001E_0000, 32'h0, 1'b0}, 0);
		send_vertex('{32'h0037_0000, 32'h001E_0000, 32'h0, 1'b0}, 0);
		send_vertex('{32'h0037_0001, 32'h001E_0000, 32'h0, 1'b1}, 0);
		drain();
		set_impact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1);
		send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 0);
		send_vertex('{32'h7FF0_0000, 32'h7FFF_0000, 32'h8000_1000, 1'b1}, 0);
		drain();
		set_impact(32'h0, 32'h0, 32'h0, 16'hFFFF, 0);
		send_vertex('{32'h0, 32'h0, 32'h0, 1'b0}, 0);
		send_vertex('{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1}, 0);
		send_vertex('{32'h00FF_0000, 32'h0, 32'h0, 1'b0}, 0);
		drain();

		// Random phases with varied impact settings.
		for (phase = 0; phase < 13; phase++) begin
			cx = ($urandom_range(0, 3) == 0) ? $urandom : near(0, 400 * 65536);
			cy = ($urandom_range(0, 3) == 0) ? $urandom : near(32'h001E_0000, 400 * 65536);
			cz = ($urandom_range(0, 3) == 0) ? $urandom : near(0, 400 * 65536);
			if (phase == 3) cx = 32'h7FFF_FFF0;
			if (phase == 6) cy = 32'h8000_0010;
			set_impact(cx, cy, cz, (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF :
				16'($urandom), 1'($urandom_range(0, 1)));
			if (phase == 5) hold_off = 1;
			for (int i = 0; i < 100; i++) begin
				v = pick_vertex(cx, cy, cz);
				send_vertex(v, (phase % 4) != 2);
			end
			vtx_valid <= 0;
			drain();
		end

		$display("Sent %0d vertices over 13 random impact settings plus directed corners;",
			sent);
		$display("%0d results were dented.", dented_count);
		if (fail_count == 0 && pending == 0)
			$display("radial_vertex_dent_top test passed");
		else
			$display("radial_vertex_dent_top test failed");
		$finish;
	end

endmodule
`default_nettype wire
